// ----- sv/bitset_store_with_scan_core_assert.svh -----
// ----------------------------------------------------------------------------
// Bitset store assertion macros
// Shared concurrent assertion wrappers, clocked on clk; the plain one is quiet during reset.
// ----------------------------------------------------------------------------
`ifndef BITSET_STORE_WITH_SCAN_CORE_ASSERT_SVH
`define BITSET_STORE_WITH_SCAN_CORE_ASSERT_SVH

// plain property, clocked on clk and disabled while arst_n is low
`define BSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// property that must also hold while reset is applied
`define BSS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/bss_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitset store package
// Request codes, internal operation codes, command and result records.
// ----------------------------------------------------------------------------
package bss_pkg;

	// request codes on the func port
	localparam logic [2:0] FUNC_SET    = 3'd0;
	localparam logic [2:0] FUNC_CLR    = 3'd1;
	localparam logic [2:0] FUNC_FLIP   = 3'd2;
	localparam logic [2:0] FUNC_TEST   = 3'd3;
	localparam logic [2:0] FUNC_INV    = 3'd4;
	localparam logic [2:0] FUNC_CLRALL = 3'd5;

	// largest byte count the index and result fields can address
	localparam int FIELD_BYTES = 64;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_SET,
		OP_CLR,
		OP_FLIP,
		OP_TEST,
		OP_INV,
		OP_CLRALL
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [5:0] byte_idx;
		logic [2:0] bit_pos;
		logic       oor;
	} cmd_t;

	typedef struct packed {
		logic              bit_value;
		logic              out_of_range;
		logic [9:0]        ones_count;
		logic signed [9:0] lowest_set;
		logic signed [9:0] highest_set;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} back_state_t;

	function automatic logic [3:0] pop8(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'd0, b[i]};
		end
		return n;
	endfunction

	function automatic logic [2:0] low8(input logic [7:0] b);
		logic [2:0] p;
		p = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (b[i]) begin
				p = 3'(i);
			end
		end
		return p;
	endfunction

	function automatic logic [2:0] high8(input logic [7:0] b);
		logic [2:0] p;
		p = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				p = 3'(i);
			end
		end
		return p;
	endfunction

endpackage

// ----- sv/bss_fifo.sv -----
// ----------------------------------------------------------------------------
// Bitset store small queue
// Register-based first-in first-out queue of a few entries.
// ----------------------------------------------------------------------------
module bss_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- sv/bss_front.sv -----
// ----------------------------------------------------------------------------
// Bitset store front end
// Decodes requests into commands, range-checks them and queues them.
// ----------------------------------------------------------------------------
module bss_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [2:0]    func,
	input  logic [8:0]    bit_index,
	input  logic [6:0]    len,
	input  logic          cmd_pop,
	output bss_pkg::cmd_t cmd,
	output logic          cmd_empty
);

	bss_pkg::cmd_t               cmd_in;
	logic [$bits(bss_pkg::cmd_t)-1:0] cmd_raw;
	logic                        oor;

	// single-bit requests whose byte lies at or past the length do nothing
	assign oor = (func <= bss_pkg::FUNC_TEST) && ({1'b0, bit_index[8:3]} >= len);

	always_comb begin
		cmd_in.byte_idx = bit_index[8:3];
		cmd_in.bit_pos  = bit_index[2:0];
		cmd_in.oor      = oor;
		unique case (func)
			bss_pkg::FUNC_SET:    cmd_in.op = oor ? bss_pkg::OP_NONE : bss_pkg::OP_SET;
			bss_pkg::FUNC_CLR:    cmd_in.op = oor ? bss_pkg::OP_NONE : bss_pkg::OP_CLR;
			bss_pkg::FUNC_FLIP:   cmd_in.op = oor ? bss_pkg::OP_NONE : bss_pkg::OP_FLIP;
			bss_pkg::FUNC_TEST:   cmd_in.op = oor ? bss_pkg::OP_NONE : bss_pkg::OP_TEST;
			bss_pkg::FUNC_INV:    cmd_in.op = bss_pkg::OP_INV;
			bss_pkg::FUNC_CLRALL: cmd_in.op = bss_pkg::OP_CLRALL;
			default:              cmd_in.op = bss_pkg::OP_NONE;
		endcase
	end

	bss_fifo #(
		.WIDTH ($bits(bss_pkg::cmd_t)),
		.DEPTH (2)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cmd_in),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_raw),
		.empty   (cmd_empty)
	);

	assign cmd = bss_pkg::cmd_t'(cmd_raw);

endmodule

// ----- sv/bss_back.sv -----
// ----------------------------------------------------------------------------
// Bitset store back end
// Byte-serial sweep over the map: applies the command and gathers the scans.
// ----------------------------------------------------------------------------
module bss_back #(
	parameter int STORE_BYTES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [6:0]    len,
	input  bss_pkg::cmd_t cmd,
	input  logic          cmd_empty,
	output logic          cmd_pop,
	output bss_pkg::res_t res,
	output logic          res_push,
	input  logic          res_full
);

	localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

	bss_pkg::back_state_t st_q, st_d;
	bss_pkg::cmd_t        cmd_q;

	logic [7:0]        mem [STORE_BYTES];
	logic              vld_q [STORE_BYTES];

	logic [6:0]        rd_cnt_q;
	logic              issue;
	logic              start;
	logic              vld_s1;
	logic [6:0]        addr_s1;
	logic [7:0]        rdata_s1;
	logic              rvld_s1;

	logic [7:0]        old_b;
	logic [7:0]        new_b;
	logic [7:0]        mask;
	logic              hit;

	logic [9:0]        cnt_q;
	logic signed [9:0] lo_q;
	logic signed [9:0] hi_q;
	logic              found_q;
	logic              bitv_q;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			bss_pkg::ST_IDLE: begin
				if (!cmd_empty) begin
					st_d = bss_pkg::ST_RUN;
				end
			end
			bss_pkg::ST_RUN: begin
				if (rd_cnt_q == len && !vld_s1) begin
					st_d = bss_pkg::ST_DONE;
				end
			end
			bss_pkg::ST_DONE: begin
				if (!res_full) begin
					st_d = bss_pkg::ST_IDLE;
				end
			end
			default: st_d = bss_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		start    = 1'b0;
		issue    = 1'b0;
		res_push = 1'b0;
		unique case (st_q)
			bss_pkg::ST_IDLE: start    = !cmd_empty;
			bss_pkg::ST_RUN:  issue    = (rd_cnt_q < len);
			bss_pkg::ST_DONE: res_push = !res_full;
			default: ;
		endcase
	end

	assign cmd_pop = start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= bss_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			if (start) begin
				rd_cnt_q <= '0;
			end else if (issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q <= cmd;
		end
		addr_s1 <= rd_cnt_q;
	end

	// map storage: one read and one write a cycle, registered read
	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1 <= mem[rd_cnt_q[AW-1:0]];
		end
		if (vld_s1) begin
			mem[addr_s1[AW-1:0]] <= new_b;
		end
	end

	// an entry never written since reset reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_BYTES; i++) begin
				vld_q[i] <= 1'b0;
			end
			rvld_s1 <= 1'b0;
		end else begin
			if (issue) begin
				rvld_s1 <= vld_q[rd_cnt_q[AW-1:0]];
			end
			if (vld_s1) begin
				vld_q[addr_s1[AW-1:0]] <= 1'b1;
			end
		end
	end

	assign old_b = rvld_s1 ? rdata_s1 : 8'h00;
	assign mask  = 8'b1 << cmd_q.bit_pos;
	assign hit   = (addr_s1 == {1'b0, cmd_q.byte_idx});

	always_comb begin
		unique case (cmd_q.op)
			bss_pkg::OP_SET:    new_b = hit ? (old_b | mask) : old_b;
			bss_pkg::OP_CLR:    new_b = hit ? (old_b & ~mask) : old_b;
			bss_pkg::OP_FLIP:   new_b = hit ? (old_b ^ mask) : old_b;
			bss_pkg::OP_INV:    new_b = ~old_b;
			bss_pkg::OP_CLRALL: new_b = 8'h00;
			default:            new_b = old_b;
		endcase
	end

	// scan accumulators
	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q   <= '0;
			lo_q    <= '1;
			hi_q    <= '1;
			found_q <= 1'b0;
			bitv_q  <= 1'b0;
		end else if (vld_s1) begin
			cnt_q <= cnt_q + {6'd0, bss_pkg::pop8(new_b)};
			if (new_b != 8'h00) begin
				hi_q <= {1'b0, addr_s1[5:0], bss_pkg::high8(new_b)};
				if (!found_q) begin
					lo_q <= {1'b0, addr_s1[5:0], bss_pkg::low8(new_b)};
				end
				found_q <= 1'b1;
			end
			if (cmd_q.op == bss_pkg::OP_TEST && hit) begin
				bitv_q <= |(old_b & mask);
			end
		end
	end

	always_comb begin
		res.bit_value    = bitv_q;
		res.out_of_range = cmd_q.oor;
		res.ones_count   = cnt_q;
		res.lowest_set   = lo_q;
		res.highest_set  = hi_q;
	end

`include "bitset_store_with_scan_core_assert.svh"

	`BSS_ASSERT(a_cnt_bound, st_q == bss_pkg::ST_RUN |-> rd_cnt_q <= len, "sweep past length")
	`BSS_ASSERT(a_s1_in_run, vld_s1 |-> st_q == bss_pkg::ST_RUN, "byte in flight outside sweep")
	`BSS_ASSERT(a_oor_noop, st_q == bss_pkg::ST_RUN && cmd_q.oor |-> cmd_q.op == bss_pkg::OP_NONE, "out-of-range request changes map")
	`BSS_ASSERT(a_push_once, res_push |=> st_q == bss_pkg::ST_IDLE, "result pushed twice")
	`BSS_ASSERT_ALWAYS(a_no_pop_busy, cmd_pop |-> st_q == bss_pkg::ST_IDLE, "command taken while busy")

endmodule

// ----- sv/bitset_store_with_scan_core.sv -----
// A request passes through the command queue, the byte sweep and the result queue before its result shows.
// The back end sweeps the map for one request at a time; up to two more wait in the command queue.
// The sweep reads and rewrites one map byte per cycle through a single memory port pair.
// Reset: map reads as all zeros, bytes_in_use = 64, both queues empty; no clearing pass.
// ----------------------------------------------------------------------------
// Bitset store with scan
// Bitmap of bytes with single-bit set/clear/flip/test, whole-map invert and
// clear, and count / lowest / highest set bit reported on every request.
// ----------------------------------------------------------------------------
module bitset_store_with_scan_core #(
	parameter int MAP_BYTES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	// request side
	input  logic              push,
	output logic              full,
	input  logic [2:0]        func,
	input  logic [8:0]        bit_index,
	// result side
	output logic              empty,
	input  logic              pop,
	output logic              bit_value,
	output logic              out_of_range,
	output logic [9:0]        ones_count,
	output logic signed [9:0] lowest_set,
	output logic signed [9:0] highest_set,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [1:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	// only the first 64 bytes are reachable through the 9-bit index
	localparam int STORE_BYTES = (MAP_BYTES < bss_pkg::FIELD_BYTES) ?
		MAP_BYTES : bss_pkg::FIELD_BYTES;

	localparam logic [1:0] ADDR_BYTES_IN_USE = 2'd0;

	logic [6:0]    bytes_in_use_q;
	logic [6:0]    len;
	logic          cfg_wr;

	bss_pkg::cmd_t cmd;
	logic          cmd_empty;
	logic          cmd_pop;
	bss_pkg::res_t res_in;
	bss_pkg::res_t res_out;
	logic          res_push;
	logic          res_full;
	logic [$bits(bss_pkg::res_t)-1:0] res_raw;

	// ---- configuration port: zero wait state, one register at offset 0
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_BYTES_IN_USE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_in_use_q <= 7'd64;
		end else if (cfg_wr) begin
			bytes_in_use_q <= pwdata[6:0];
		end
	end

	assign prdata = (paddr == ADDR_BYTES_IN_USE) ? {25'd0, bytes_in_use_q} : 32'd0;

	// effective length: register value capped at the physical store
	assign len = (bytes_in_use_q > 7'(STORE_BYTES)) ? 7'(STORE_BYTES) : bytes_in_use_q;

	// ---- front: decode, range check, command queue
	bss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.func      (func),
		.bit_index (bit_index),
		.len       (len),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.cmd_empty (cmd_empty)
	);

	// ---- back: byte sweep that updates the map and builds the scans
	bss_back #(
		.STORE_BYTES (STORE_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.len       (len),
		.cmd       (cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res       (res_in),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	// ---- result queue: lets the sweep finish while the consumer stalls
	bss_fifo #(
		.WIDTH ($bits(bss_pkg::res_t)),
		.DEPTH (2)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_raw),
		.empty   (empty)
	);

	assign res_out      = bss_pkg::res_t'(res_raw);
	assign bit_value    = res_out.bit_value;
	assign out_of_range = res_out.out_of_range;
	assign ones_count   = res_out.ones_count;
	assign lowest_set   = res_out.lowest_set;
	assign highest_set  = res_out.highest_set;

endmodule
